// ===== rtl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg: shared types and codes of the sorted timer queue
// Operation and result codes, the cell row command, and the structs that pass
// between the queue controller and the cells.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int ID_W      = 4;
  localparam int DL_W      = 64;
  localparam int NUM_IDS   = 16;
  localparam int STQ_DEPTH = 16;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Result kinds of an output beat.
  localparam logic [1:0] KIND_EXPIRED  = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_NONE_DUE = 2'd2;
  localparam logic [1:0] KIND_REJECTED = 2'd3;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_POP
  } sts_cmd_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    sts_cmd_t            cmd;
    logic [DL_W-1:0]     key;
    logic [ID_W-1:0]     id;
  } sts_ctl_t;

  // What one cell shows to its neighbors and to the controller.
  typedef struct packed {
    logic                valid;
    logic                lt;
    logic                due;
    logic                gone;
    logic [DL_W-1:0]     dl;
    logic [ID_W-1:0]     id;
  } sts_cell_out_t;

endpackage

// ===== rtl/sts_cell.sv =====
// ----------------------------------------------------------------------------
// sts_cell: one position of the sorted timer row
// Holds one entry and, on a row command, keeps it or takes the new entry or
// the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module sts_cell
  import sts_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  sts_ctl_t      ctl,
  input  sts_cell_out_t left,
  input  sts_cell_out_t right,
  output sts_cell_out_t cur
);

  logic            valid_r, valid_nxt;
  logic [DL_W-1:0] dl_r, dl_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic            lt, due, gone;

  always_comb begin
    lt   = valid_r && (dl_r < ctl.key);
    due  = valid_r && (dl_r <= ctl.key);
    // Set from the removed entry onward, so every cell behind it moves left.
    gone = left.gone || (valid_r && (id_r == ctl.id));

    valid_nxt = valid_r;
    dl_nxt    = dl_r;
    id_nxt    = id_r;
    case (ctl.cmd)
      CMD_INSERT: begin
        if (!lt) begin
          valid_nxt = valid_r || left.valid;
          if (left.lt) begin
            dl_nxt = ctl.key;
            id_nxt = ctl.id;
          end else begin
            dl_nxt = left.dl;
            id_nxt = left.id;
          end
        end
      end
      CMD_REMOVE: begin
        if (gone) begin
          valid_nxt = right.valid;
          dl_nxt    = right.dl;
          id_nxt    = right.id;
        end
      end
      CMD_POP: begin
        valid_nxt = right.valid;
        dl_nxt    = right.dl;
        id_nxt    = right.id;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    dl_r <= dl_nxt;
    id_r <= id_nxt;
  end

  assign cur = '{valid: valid_r, lt: lt, due: due, gone: gone, dl: dl_r, id: id_r};

endmodule

// ===== rtl/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue: deadline-ordered timer queue
// A row of cells keeps the queued entries sorted by deadline; a small
// controller runs insert, remove and tick and returns the result beats.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries (at most 16, one per identifier) in a
// row of cells sorted by deadline, earliest at the head. Insert and remove
// update the whole row at once, by a compare and a shift in every cell, and
// their single result beat is formed in the response state after that,
// where the next input beat can be taken as the beat is registered. A tick
// pops one due entry off the head of the row per cycle while the output is
// not stalled, giving one expired beat per entry; a tick with nothing due
// gives one beat of kind none due. A stalled output holds each step back.
// Inserting into a full queue or an identifier already queued, removing an
// identifier not queued, and an unused operation code each give one beat of
// kind rejected and leave the queue unchanged.
module sorted_timer_queue
  import sts_pkg::*;
#(
  parameter int DEPTH = STQ_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_op,
  input  logic [ID_W-1:0] in_entry_id,
  input  logic [DL_W-1:0] in_deadline,
  input  logic [DL_W-1:0] in_now,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_kind,
  output logic [ID_W-1:0] out_expired_id,
  output logic            out_last,
  output logic            out_queue_empty,
  output logic [DL_W-1:0] out_next_deadline
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  localparam sts_cell_out_t HEAD_EDGE =
    '{valid: 1'b1, lt: 1'b1, due: 1'b0, gone: 1'b0, dl: '0, id: '0};
  localparam sts_cell_out_t TAIL_EDGE =
    '{valid: 1'b0, lt: 1'b0, due: 1'b0, gone: 1'b0, dl: '0, id: '0};

  state_t               state_r, state_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [DL_W-1:0]      key_r, key_nxt;
  logic                 reject_r, reject_nxt;
  logic [NUM_IDS-1:0]   queued_r, queued_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [ID_W-1:0]      exp_id_r, exp_id_nxt;
  logic                 last_r, last_nxt;
  logic                 empty_r, empty_nxt;
  logic [DL_W-1:0]      next_dl_r, next_dl_nxt;

  sts_ctl_t             ctl;
  sts_cell_out_t        cell_q [DEPTH];
  sts_cell_out_t        left_s [DEPTH];
  sts_cell_out_t        right_s[DEPTH];
  sts_cell_out_t        head, second;
  logic                 out_free;
  logic                 accept;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_s[i] = HEAD_EDGE;
    end else begin : g_left
      assign left_s[i] = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_s[i] = TAIL_EDGE;
    end else begin : g_right
      assign right_s[i] = cell_q[i+1];
    end
    sts_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .left  (left_s[i]),
      .right (right_s[i]),
      .cur   (cell_q[i])
    );
  end

  assign head     = cell_q[0];
  assign second   = cell_q[1];
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_RESP) && out_free));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    key_nxt       = key_r;
    reject_nxt    = reject_r;
    queued_nxt    = queued_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    exp_id_nxt    = exp_id_r;
    last_nxt      = last_r;
    empty_nxt     = empty_r;
    next_dl_nxt   = next_dl_r;
    ctl.cmd       = CMD_NONE;
    ctl.key       = key_r;
    ctl.id        = id_r;

    if (accept) begin
      op_nxt  = in_op;
      id_nxt  = in_entry_id;
      key_nxt = (in_op == OP_TICK) ? in_now : in_deadline;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_INSERT: begin
            state_nxt = S_RESP;
            if (queued_r[id_r] || (count_r >= CNT_W'(DEPTH))) begin
              reject_nxt = 1'b1;
            end else begin
              reject_nxt         = 1'b0;
              ctl.cmd            = CMD_INSERT;
              queued_nxt[id_r]   = 1'b1;
              count_nxt          = count_r + CNT_W'(1);
            end
          end
          OP_REMOVE: begin
            state_nxt = S_RESP;
            if (!queued_r[id_r]) begin
              reject_nxt = 1'b1;
            end else begin
              reject_nxt         = 1'b0;
              ctl.cmd            = CMD_REMOVE;
              queued_nxt[id_r]   = 1'b0;
              count_nxt          = count_r - CNT_W'(1);
            end
          end
          OP_TICK: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              if (head.due) begin
                // Pop the head; the entry behind it decides whether more follow.
                ctl.cmd              = CMD_POP;
                queued_nxt[head.id]  = 1'b0;
                count_nxt            = count_r - CNT_W'(1);
                kind_nxt             = KIND_EXPIRED;
                exp_id_nxt           = head.id;
                last_nxt             = !second.due;
                empty_nxt            = !second.valid;
                next_dl_nxt          = second.valid ? second.dl : '0;
                if (!second.due) begin
                  state_nxt = S_IDLE;
                end
              end else begin
                kind_nxt    = KIND_NONE_DUE;
                exp_id_nxt  = '0;
                last_nxt    = 1'b1;
                empty_nxt   = !head.valid;
                next_dl_nxt = head.valid ? head.dl : '0;
                state_nxt   = S_IDLE;
              end
            end
          end
          default: begin
            reject_nxt = 1'b1;
            state_nxt  = S_RESP;
          end
        endcase
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = reject_r ? KIND_REJECTED : KIND_ACCEPTED;
          exp_id_nxt    = '0;
          last_nxt      = 1'b1;
          empty_nxt     = !head.valid;
          next_dl_nxt   = head.valid ? head.dl : '0;
          state_nxt     = accept ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      queued_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      reject_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      queued_r    <= queued_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      reject_r    <= reject_nxt;
    end
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    key_r     <= key_nxt;
    kind_r    <= kind_nxt;
    exp_id_r  <= exp_id_nxt;
    last_r    <= last_nxt;
    empty_r   <= empty_nxt;
    next_dl_r <= next_dl_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_expired_id    = exp_id_r;
  assign out_last          = last_r;
  assign out_queue_empty   = empty_r;
  assign out_next_deadline = next_dl_r;

endmodule
